>>> hdl/spet_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the switching phase exposure tracker.
// No dependencies; used by the interfaces, the register file, the divider and the top level.
package spet_pkg;

  localparam int MAX_PHASE_SLOTS_DEF = 16;

  localparam int CODE_W  = 4;
  localparam int TS_W    = 63;
  localparam int STAT_W  = 2;
  localparam int PIDX_W  = 4;
  localparam int CYC_W   = 11;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

  // register indexes
  localparam logic [1:0] REG_PHASE_COUNT = 2'd0;
  localparam logic [1:0] REG_CYC_PER_EXP = 2'd1;
  localparam logic [1:0] REG_EXP_LENGTH  = 2'd2;
  localparam logic [1:0] REG_PATTERN     = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd1;
  localparam logic [STAT_W-1:0] STAT_STUCK   = 2'd2;

  // divider operand widths
  localparam logic [1:0] DIV_W16 = 2'd0;
  localparam logic [1:0] DIV_W32 = 2'd1;
  localparam logic [1:0] DIV_W64 = 2'd2;

  localparam int DVD_W = 64;
  localparam int DSR_W = 32;

  typedef struct packed {
    logic [4:0]  phase_count;
    logic [9:0]  cyc_per_exp;
    logic [31:0] exp_length;
    logic [31:0] pattern;
    logic        len_wr;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [1:0]       width;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } div_rsp_t;

endpackage

>>> hdl/spet_in_if.sv
`timescale 1ns / 1ps
// Input channel: phase code and timestamp with valid/ready.
// Depends on spet_pkg.
interface spet_in_if;
  logic                      valid;
  logic                      ready;
  logic [spet_pkg::CODE_W-1:0] phase_code;
  logic [spet_pkg::TS_W-1:0]   timestamp;

  modport source (output valid, phase_code, timestamp, input ready);
  modport sink   (input valid, phase_code, timestamp, output ready);
endinterface

>>> hdl/spet_out_if.sv
`timescale 1ns / 1ps
// Result channel: exposure flag, status, phase index and cycle number with valid/ready.
// Depends on spet_pkg.
interface spet_out_if;
  logic                               valid;
  logic                               ready;
  logic                               exposure_done;
  logic [spet_pkg::STAT_W-1:0]        status;
  logic [spet_pkg::PIDX_W-1:0]        phase_index;
  logic signed [spet_pkg::CYC_W-1:0]  cycle_number;

  modport source (output valid, exposure_done, status, phase_index, cycle_number,
                  input ready);
  modport sink   (input valid, exposure_done, status, phase_index, cycle_number,
                  output ready);
endinterface

>>> hdl/spet_cfg.sv
`timescale 1ns / 1ps
// APB register file for the tracker configuration.
// Depends on spet_pkg.
module spet_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spet_pkg::PADDR_W-1:0] paddr,
  input  logic [spet_pkg::PDATA_W-1:0] pwdata,
  output logic [spet_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output spet_pkg::cfg_t               cfg
);
  import spet_pkg::*;

  logic [4:0]  phase_count;
  logic [9:0]  cyc_per_exp;
  logic [31:0] exp_length;
  logic [31:0] pattern;
  logic        wr;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= 5'd1;
      cyc_per_exp <= 10'd1;
      exp_length  <= 32'd1;
      pattern     <= 32'd0;
    end else if (wr) begin
      case (idx)
        REG_PHASE_COUNT: phase_count <= pwdata[4:0];
        REG_CYC_PER_EXP: cyc_per_exp <= pwdata[9:0];
        REG_EXP_LENGTH:  exp_length  <= pwdata;
        REG_PATTERN:     pattern     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PHASE_COUNT: prdata = {27'd0, phase_count};
      REG_CYC_PER_EXP: prdata = {22'd0, cyc_per_exp};
      REG_EXP_LENGTH:  prdata = exp_length;
      REG_PATTERN:     prdata = pattern;
      default:         prdata = '0;
    endcase
  end

  assign cfg.phase_count = phase_count;
  assign cfg.cyc_per_exp = cyc_per_exp;
  assign cfg.exp_length  = exp_length;
  assign cfg.pattern     = pattern;
  assign cfg.len_wr      = wr && (idx == REG_EXP_LENGTH);

endmodule

>>> hdl/spet_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle; 16, 32 or 64 dividend bits.
// Depends on spet_pkg.
module spet_div (
  input  logic                clk,
  input  logic                rst,
  input  spet_pkg::div_req_t  req,
  output spet_pkg::div_rsp_t  rsp
);
  import spet_pkg::*;

  logic             busy;
  logic             done;
  logic [6:0]       cnt;
  logic [DVD_W-1:0] dvd;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DSR_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem, dvd[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        case (req.width)
          DIV_W16: begin
            cnt <= 7'd16;
            dvd <= req.dividend << 48;
          end
          DIV_W32: begin
            cnt <= 7'd32;
            dvd <= req.dividend << 32;
          end
          default: begin
            cnt <= 7'd64;
            dvd <= req.dividend;
          end
        endcase
        dsr <= req.divisor;
        rem <= '0;
        quo <= '0;
      end else if (busy) begin
        rem <= ge ? DSR_W'(rem_sh - {1'b0, dsr}) : rem_sh[DSR_W-1:0];
        quo <= {quo[DVD_W-2:0], ge};
        dvd <= {dvd[DVD_W-2:0], 1'b0};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

>>> hdl/switching_phase_exposure_tracker.sv
`timescale 1ns / 1ps
// Switching phase exposure tracker: a sequencer drives one shared bit-serial divider.
// Count mode: at most one 64-bit division per item. Phase mode: up to seven divisions of
// 32, 32, 64, 16, 64, 64 and 16 bits, one bit per cycle. A length write loads the end mark.
// One item in flight; the next beat is taken once the result sits in the output register.
// Synchronous reset clears phase, cycle and last timestamp and sets the end mark to one.
module switching_phase_exposure_tracker #(
  parameter int MAX_PHASE_SLOTS = spet_pkg::MAX_PHASE_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spet_pkg::PADDR_W-1:0] paddr,
  input  logic [spet_pkg::PDATA_W-1:0] pwdata,
  output logic [spet_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  spet_in_if.sink                      in_ch,
  spet_out_if.source                   out_ch
);
  import spet_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DISP   = 4'd1;
  localparam logic [3:0] ST_CM_DIV = 4'd2;
  localparam logic [3:0] ST_P_D1   = 4'd3;
  localparam logic [3:0] ST_P_D2   = 4'd4;
  localparam logic [3:0] ST_P_D3   = 4'd5;
  localparam logic [3:0] ST_P_D4   = 4'd6;
  localparam logic [3:0] ST_P_S5   = 4'd7;
  localparam logic [3:0] ST_P_D5   = 4'd8;
  localparam logic [3:0] ST_P_D6   = 4'd9;
  localparam logic [3:0] ST_CORR   = 4'd10;
  localparam logic [3:0] ST_P_D7   = 4'd11;
  localparam logic [3:0] ST_FIN    = 4'd12;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  spet_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  spet_div u_div (.clk, .rst, .req(div_req), .rsp(div_rsp));

  // architectural state
  logic [PIDX_W-1:0]        phase_now;
  logic signed [CYC_W-1:0]  cur_cycle;
  logic [TS_W-1:0]          prev_ts;
  logic [TS_W-1:0]          end_mark;

  // sequencer and working registers
  logic [3:0]         state;
  logic [TS_W-1:0]    ts_r;
  logic [1:0]         code_r;
  logic [TS_W-1:0]    diff;
  logic [DVD_W-1:0]   m1;
  logic signed [11:0] cyc;
  logic [PIDX_W-1:0]  cur;
  logic [1:0]         expo;
  logic [PIDX_W-1:0]  idx_r;
  logic               corr;
  logic               res_done;
  logic [STAT_W-1:0]  res_status;

  logic             div_go;
  logic [1:0]       div_wd;
  logic [DVD_W-1:0] div_dvd;
  logic [DSR_W-1:0] div_dsr;

  logic                     out_valid;
  logic                     out_done;
  logic [STAT_W-1:0]        out_status;
  logic [PIDX_W-1:0]        out_phase;
  logic signed [CYC_W-1:0]  out_cycle;

  assign div_req.start    = div_go;
  assign div_req.width    = div_wd;
  assign div_req.dividend = div_dvd;
  assign div_req.divisor  = div_dsr;

  // effective configuration
  logic [4:0]         n_eff;
  logic [9:0]         cpe_eff;
  logic [31:0]        len_eff;
  logic signed [11:0] cpe_s;
  logic signed [63:0] cpe64;

  assign n_eff   = (cfg.phase_count > 5'(MAX_PHASE_SLOTS)) ? 5'(MAX_PHASE_SLOTS)
                                                           : cfg.phase_count;
  assign cpe_eff = (cfg.cyc_per_exp == 10'd0) ? 10'd1 : cfg.cyc_per_exp;
  assign len_eff = (cfg.exp_length == 32'd0) ? 32'd1 : cfg.exp_length;
  assign cpe_s   = signed'({2'b00, cpe_eff});
  assign cpe64   = signed'({54'd0, cpe_eff});

  // phase table lookup: first phase whose code matches
  logic              lk_found;
  logic [PIDX_W-1:0] lk_idx;

  always_comb begin
    lk_found = 1'b0;
    lk_idx   = '0;
    for (int i = 0; i < MAX_PHASE_SLOTS; i++) begin
      if (!lk_found && (5'(i) < n_eff) &&
          ((cfg.pattern[2*i +: 2] ^ 2'b11) == code_r)) begin
        lk_found = 1'b1;
        lk_idx   = PIDX_W'(i);
      end
    end
  end

  // (a mod n) for a <= 16, n >= 2: at most eight subtractions
  function automatic logic [4:0] mod_small(logic [4:0] a, logic [4:0] n);
    logic [4:0] v;
    v = a;
    for (int k = 0; k < 8; k++) begin
      if (v >= n) v = v - n;
    end
    return v;
  endfunction

  logic [PIDX_W-1:0]  cur1;
  logic signed [11:0] cyc_inc;
  logic signed [63:0] t_val;
  logic [1:0]         expo_add;
  logic [63:0]        cm_sum;
  logic [TS_W-1:0]    cm_end;

  assign cur1     = PIDX_W'(mod_small({1'b0, phase_now} + 5'd1, n_eff));
  assign cyc_inc  = cyc + ((cur1 == '0) ? 12'sd1 : 12'sd0);
  assign t_val    = {{52{cyc[11]}}, cyc} + signed'(div_rsp.quotient);
  assign expo_add = ((expo != 2'd0) || (div_rsp.quotient > 64'd1)) ? 2'd2 : 2'd1;

  // count mode: end mark = first step at or past ts; one step on if ts equals the old mark
  always_comb begin
    if (div_rsp.quotient == '0 && div_rsp.remainder == '0) begin
      cm_sum = {1'b0, end_mark} + 64'(len_eff);
    end else begin
      cm_sum = {1'b0, ts_r} - 64'(div_rsp.remainder)
             + ((div_rsp.remainder != '0) ? 64'(len_eff) : 64'd0);
    end
    cm_end = (cm_sum > {1'b0, TS_MAX}) ? TS_MAX : cm_sum[TS_W-1:0];
  end

  // over/under correction across the cycle boundary
  logic [PIDX_W-1:0]  last;
  logic               over;
  logic               under;
  logic signed [11:0] cyc_c;
  logic [1:0]         expo_c;

  always_comb begin
    last   = PIDX_W'(n_eff - 5'd1);
    over   = corr && (cur != idx_r) && (cur == '0) && (idx_r == last);
    under  = corr && (cur != idx_r) && (cur == last) && (idx_r == '0);
    cyc_c  = cyc;
    expo_c = expo;
    if (over) begin
      cyc_c = cyc - 12'sd1;
      if (expo != 2'd0 && cyc_c < 12'sd0) begin
        cyc_c  = 12'sd0;
        expo_c = expo - 2'd1;
      end
    end else if (under) begin
      cyc_c = cyc + 12'sd1;
      if (cyc_c >= cpe_s) begin
        cyc_c  = 12'sd0;
        expo_c = 2'd2;
      end
    end else if (!corr && idx_r == '0 && cur != '0) begin
      cyc_c = cyc + 12'sd1;
    end
  end

  assign in_ch.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_go    <= 1'b0;
      out_valid <= 1'b0;
      phase_now <= '0;
      cur_cycle <= '0;
      prev_ts   <= '0;
      end_mark  <= TS_W'(1);
    end else begin
      // start pulse lasts one cycle; no state issues a new one right after
      if (div_go) div_go <= 1'b0;
      if (out_valid && out_ch.ready && state != ST_FIN) out_valid <= 1'b0;
      if (cfg.len_wr) begin
        end_mark <= TS_W'(pwdata);
      end else if (state == ST_CM_DIV && div_rsp.done) begin
        end_mark <= cm_end;
      end

      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            ts_r   <= in_ch.timestamp;
            code_r <= in_ch.phase_code[1:0];
            state  <= ST_DISP;
          end
        end

        ST_DISP: begin
          res_done <= 1'b0;
          if (cfg.phase_count < 5'd2) begin
            res_status <= STAT_OK;
            if (ts_r < end_mark) begin
              state <= ST_FIN;
            end else begin
              div_go  <= 1'b1;
              div_wd  <= DIV_W64;
              div_dvd <= 64'(ts_r - end_mark);
              div_dsr <= len_eff;
              state   <= ST_CM_DIV;
            end
          end else begin
            prev_ts <= ts_r;
            idx_r   <= lk_idx;
            diff    <= (ts_r > prev_ts) ? ts_r - prev_ts : '0;
            cyc     <= {cur_cycle[CYC_W-1], cur_cycle};
            cur     <= phase_now;
            expo    <= 2'd0;
            if (!lk_found) begin
              res_status <= STAT_UNKNOWN;
              state      <= ST_FIN;
            end else if (ts_r == prev_ts) begin
              phase_now  <= lk_idx;
              res_status <= STAT_STUCK;
              state      <= ST_FIN;
            end else begin
              res_status <= STAT_OK;
              div_go     <= 1'b1;
              div_wd     <= DIV_W32;
              div_dvd    <= 64'(cfg.exp_length);
              div_dsr    <= 32'(cpe_eff);
              state      <= ST_P_D1;
            end
          end
        end

        ST_CM_DIV: begin
          if (div_rsp.done) begin
            res_done <= 1'b1;
            state    <= ST_FIN;
          end
        end

        ST_P_D1: begin
          if (div_rsp.done) begin
            div_go  <= 1'b1;
            div_wd  <= DIV_W32;
            div_dvd <= div_rsp.quotient;
            div_dsr <= 32'(n_eff);
            state   <= ST_P_D2;
          end
        end

        ST_P_D2: begin
          if (div_rsp.done) begin
            if (diff == '0) begin
              corr  <= 1'b0;
              state <= ST_CORR;
            end else begin
              div_go  <= 1'b1;
              div_wd  <= DIV_W64;
              div_dvd <= 64'(diff);
              // zero counts per phase acts as one
              div_dsr <= (div_rsp.quotient == '0) ? 32'd1 : div_rsp.quotient[DSR_W-1:0];
              state   <= ST_P_D3;
            end
          end
        end

        ST_P_D3: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient == '0) begin
              corr  <= 1'b0;
              state <= ST_CORR;
            end else begin
              corr <= 1'b1;
              cur  <= cur1;
              m1   <= div_rsp.quotient - 64'd1;
              if (cyc_inc >= cpe_s) begin
                expo    <= 2'd1;
                div_go  <= 1'b1;
                div_wd  <= DIV_W16;
                div_dvd <= 64'(unsigned'(cyc_inc));
                div_dsr <= 32'(cpe_eff);
                state   <= ST_P_D4;
              end else begin
                cyc   <= cyc_inc;
                state <= ST_P_S5;
              end
            end
          end
        end

        ST_P_D4: begin
          if (div_rsp.done) begin
            cyc   <= signed'(div_rsp.remainder[11:0]);
            state <= ST_P_S5;
          end
        end

        ST_P_S5: begin
          div_go  <= 1'b1;
          div_wd  <= DIV_W64;
          div_dvd <= 64'(cur) + m1;
          div_dsr <= 32'(n_eff);
          state   <= ST_P_D5;
        end

        ST_P_D5: begin
          if (div_rsp.done) begin
            cur <= div_rsp.remainder[PIDX_W-1:0];
            if (t_val >= cpe64) begin
              div_go  <= 1'b1;
              div_wd  <= DIV_W64;
              div_dvd <= unsigned'(t_val);
              div_dsr <= 32'(cpe_eff);
              state   <= ST_P_D6;
            end else begin
              cyc   <= t_val[11:0];
              state <= ST_CORR;
            end
          end
        end

        ST_P_D6: begin
          if (div_rsp.done) begin
            cyc   <= signed'(div_rsp.remainder[11:0]);
            expo  <= expo_add;
            state <= ST_CORR;
          end
        end

        ST_CORR: begin
          phase_now <= idx_r;
          cyc       <= cyc_c;
          if (cyc_c >= cpe_s) begin
            res_done <= 1'b1;
            div_go   <= 1'b1;
            div_wd   <= DIV_W16;
            div_dvd  <= 64'(unsigned'(cyc_c));
            div_dsr  <= 32'(cpe_eff);
            state    <= ST_P_D7;
          end else begin
            cur_cycle <= cyc_c[CYC_W-1:0];
            res_done  <= (expo_c != 2'd0);
            state     <= ST_FIN;
          end
        end

        ST_P_D7: begin
          if (div_rsp.done) begin
            cur_cycle <= signed'(div_rsp.remainder[CYC_W-1:0]);
            state     <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_done   <= res_done;
            out_status <= res_status;
            out_phase  <= phase_now;
            out_cycle  <= cur_cycle;
            state      <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.exposure_done = out_done;
  assign out_ch.status        = out_status;
  assign out_ch.phase_index   = out_phase;
  assign out_ch.cycle_number  = out_cycle;

`ifndef SYNTHESIS
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("result beat raised outside finish step");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state == ST_DISP))
    else $error("accepted beat not dispatched");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for switching_phase_exposure_tracker: random and directed beats through an APB
// setup, with an in-order predictor of every result field. Depends on spet_pkg and both
// channel interfaces (spet_in_if, spet_out_if).
module testbench;
  import spet_pkg::*;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [TS_W-1:0]   ts;
  } sample_t;

  typedef struct {
    logic              done;
    logic [STAT_W-1:0] status;
    logic [PIDX_W-1:0] pidx;
    logic [CYC_W-1:0]  cyc;
  } verdict_t;

  localparam longint unsigned TS_ALL = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int HOLD_CYCLES = 1500;
  localparam int SETTLE_CYCLES = 400;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  spet_in_if  in_ch ();
  spet_out_if out_ch ();

  switching_phase_exposure_tracker u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready), .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of registers and state
  logic [4:0]  m_phases;
  logic [9:0]  m_cpe;
  logic [31:0] m_len;
  logic [31:0] m_pattern;
  logic [3:0]  m_phase;
  int          m_cycle;
  longint unsigned m_prev_ts;
  longint unsigned m_end_mark;

  sample_t  pending_q[$];
  verdict_t expected_q[$];
  int send_idle = 29, recv_idle = 60;
  int hold_reqs = 0, hold_served = 0, hold_cnt = 0;
  int errors = 0;
  int stall_cycles = 0;

  function automatic logic [1:0] phase_code_of(input logic [31:0] pat, input int i);
    return ((pat >> (2 * i)) & 2'b11) ^ 2'b11;
  endfunction

  function automatic longint unsigned phase_span();
    longint unsigned n, cpe, cpp;
    n = (m_phases > 16) ? 16 : m_phases;
    cpe = (m_cpe != 0) ? m_cpe : 1;
    cpp = (longint'(m_len) / cpe) / n;
    return (cpp == 0) ? 1 : cpp;
  endfunction

  function automatic verdict_t track_exposure(input sample_t s);
    verdict_t v;
    longint unsigned ts, len, k, n, cpe, cpp, missed, prev, pos, w;
    longint signed cyc, expo, t, cpe_s;
    int idx;
    bit found, corrected, over, under;
    int unsigned cur;
    ts = longint'(s.ts);
    v.status = STAT_OK;
    v.done = 1'b0;
    if (m_phases < 2) begin
      len = (m_len != 0) ? m_len : 1;
      if (ts >= m_end_mark) begin
        v.done = 1'b1;
        k = 1;
        if (ts > m_end_mark + len) k = (ts - m_end_mark + len - 1) / len;
        if (k > (TS_ALL - m_end_mark) / len) m_end_mark = TS_ALL;
        else m_end_mark += k * len;
      end
    end else begin
      n = (m_phases > 16) ? 16 : m_phases;
      cpe = (m_cpe != 0) ? m_cpe : 1;
      cpe_s = cpe;
      found = 0;
      idx = 0;
      for (int i = 0; i < n; i++) begin
        if (!found && phase_code_of(m_pattern, i) == s.code[1:0]) begin
          found = 1;
          idx = i;
        end
      end
      prev = m_prev_ts;
      m_prev_ts = ts;
      if (!found) begin
        v.status = STAT_UNKNOWN;
      end else if (ts == prev) begin
        m_phase = idx;
        v.status = STAT_STUCK;
      end else begin
        cpp = phase_span();
        missed = (ts > prev) ? (ts - prev) / cpp : 0;
        corrected = missed > 0;
        cyc = m_cycle;
        expo = 0;
        cur = m_phase;
        if (corrected) begin
          cur = (cur + 1) % n;
          if (cur == 0) cyc++;
          if (cyc >= cpe_s) begin
            expo++;
            cyc = cyc % cpe_s;
          end
          missed--;
          pos = cur + missed;
          w = pos / n;
          cur = pos % n;
          t = cyc + longint'(w);
          if (t >= cpe_s) begin
            expo += t / cpe_s;
            t = t % cpe_s;
          end
          cyc = t;
        end
        if (corrected && cur != idx) begin
          over = 0;
          under = 0;
          if (cur == 0 && idx == n - 1) begin
            over = 1;
            cyc--;
          end else if (cur == n - 1 && idx == 0) begin
            under = 1;
            cyc++;
          end
          if (over && expo > 0 && cyc < 0) begin
            cyc = 0;
            expo--;
          end
          if (under && cyc >= cpe_s) begin
            expo++;
            cyc = cyc % cpe_s;
          end
        end
        if (!corrected && idx == 0 && cur != 0) cyc++;
        m_phase = idx;
        if (cyc >= cpe_s || expo > 0) begin
          cyc = cyc % cpe_s;
          v.done = 1'b1;
        end
        m_cycle = int'(cyc);
      end
    end
    v.pidx = m_phase;
    v.cyc = m_cycle[CYC_W-1:0];
    return v;
  endfunction

  // sender
  always @(posedge clk) begin
    sample_t s;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s.code = in_ch.phase_code;
        s.ts = in_ch.timestamp;
        expected_q.push_back(track_exposure(s));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          s = pending_q.pop_front();
          in_ch.phase_code <= s.code;
          in_ch.timestamp <= s.ts;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    verdict_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          e = expected_q.pop_front();
          if (out_ch.exposure_done !== e.done || out_ch.status !== e.status ||
              out_ch.phase_index !== e.pidx || out_ch.cycle_number !== e.cyc) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp done=%0d st=%0d ph=%0d cyc=%0d, got %0d %0d %0d %0d",
                       e.done, e.status, e.pidx, $signed(e.cyc), out_ch.exposure_done,
                       out_ch.status, out_ch.phase_index, out_ch.cycle_number);
          end
        end
      end
      if (hold_served != hold_reqs) begin
        hold_served++;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // watchdog on lack of progress
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (pending_q.size() == 0 && expected_q.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PHASE_COUNT: m_phases = val[4:0];
      REG_CYC_PER_EXP: m_cpe = val[9:0];
      REG_EXP_LENGTH: begin
        m_len = val;
        m_end_mark = val;
      end
      default: m_pattern = val;
    endcase
  endtask

  task automatic setup(input logic [4:0] pc, input logic [9:0] cpe, input logic [31:0] len,
                       input logic [31:0] pat);
    apb_write(REG_PHASE_COUNT, 32'(pc));
    apb_write(REG_CYC_PER_EXP, 32'(cpe));
    apb_write(REG_EXP_LENGTH, len);
    apb_write(REG_PATTERN, pat);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_q.size() > 0 || in_ch.valid || expected_q.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [TS_W-1:0] rand_ts();
    return TS_W'({$urandom, $urandom});
  endfunction

  task automatic push(input int unsigned code, input longint unsigned ts);
    sample_t s;
    s.code = CODE_W'(code);
    s.ts = TS_W'(ts);
    pending_q.push_back(s);
  endtask

  // mostly in-order phase walks; some noise, repeats, backward steps and wild jumps
  task automatic walk(input int count);
    longint unsigned ts, cpp, n, gap, len;
    int ph, d, r;
    ts = $urandom_range(1000);
    ph = 0;
    n = (m_phases > 16) ? 16 : ((m_phases < 2) ? 1 : m_phases);
    cpp = phase_span();
    len = (m_len != 0) ? m_len : 1;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (m_phases < 2) begin
        if (r < 5) ts = rand_ts();
        else begin
          gap = {$urandom, $urandom};
          ts += gap % (len * 2 + 1);
          ts &= TS_ALL;
        end
        push($urandom, ts);
      end else if (r < 80) begin
        d = $urandom_range(1, (r < 60) ? 1 : 2 * n + 1);
        ph = (ph + d) % n;
        ts = (ts + d * cpp + $urandom_range(0, cpp > 2 ? 2 : 0)) & TS_ALL;
        if (r < 4) ts -= d * cpp;
        push({$urandom_range(3), phase_code_of(m_pattern, ph)}, ts);
      end else if (r < 87) begin
        push($urandom, ts);
      end else if (r < 92) begin
        push($urandom, ts - $urandom_range(1, 50));
      end else begin
        ts = (r < 95) ? rand_ts() : ts + {$urandom_range(255), $urandom};
        ts &= TS_ALL;
        push($urandom, ts);
      end
    end
  endtask

  initial begin
    m_phases = 1;
    m_cpe = 1;
    m_len = 1;
    m_pattern = 0;
    m_phase = 0;
    m_cycle = 0;
    m_prev_ts = 0;
    m_end_mark = 1;
    in_ch.valid = 1'b0;
    in_ch.phase_code = '0;
    in_ch.timestamp = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: count mode, end mark one
    push(4'h0, '0);
    push(4'hF, 63'd1);
    push(4'h5, TS_MAX);
    push(4'hA, 63'd5);
    walk(100);
    drain();

    // four phases, code 0 absent from the table
    setup(5'd4, 10'd3, 32'd1200, 32'hA5A5_5A64);
    push(4'h0, 63'd100);
    push(4'hC, 63'd200);
    push(4'h3, 63'd200);
    push(4'h3, 63'd100);
    push(4'h2, 63'd400);
    push(4'hE, 63'd2000);
    push(4'h1, TS_MAX);
    push(4'h3, '0);
    walk(150);
    hold_reqs++;
    drain();

    send_idle = 60;
    recv_idle = 29;
    setup(5'd16, 10'd1023, 32'hFFFF_FFFF, $urandom);
    walk(150);
    drain();
    setup(5'd2, 10'd1, 32'd0, $urandom);
    walk(150);
    drain();

    send_idle = 0;
    recv_idle = 0;
    setup(5'd31, 10'd0, 32'd37, $urandom);
    walk(150);
    drain();
    setup(5'd0, 10'd7, $urandom, $urandom);
    walk(100);
    drain();
    setup(5'd3, 10'd2, 32'd9, 32'h0000_0006);
    walk(100);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
